// ===== hw/rtl/dxpf_pkg.sv =====
// dxpf_pkg: types and constants for the oscillator pull frame encoder
// no dependencies
`default_nettype none
package dxpf_pkg;
    localparam int unsigned NUM_W = 54;
    localparam int unsigned DEN_W = 31;
    localparam int unsigned CNT_W = 6;
    localparam logic [21:0] LIMIT_M0 = 22'd32767;
    localparam logic [21:0] LIMIT_M1 = 22'd4194303;
    localparam logic [21:0] RANGE_K = 22'd4005425;           // 25 * 160217
    localparam logic [30:0] DEN_M0 = 31'd5242720;            // 32767 * 160
    localparam logic [30:0] DEN_M1 = 31'd671088480;          // 4194303 * 160
    localparam logic [7:0] HDR_HI = 8'hFA;
    localparam logic [3:0] HDR_LO = 4'hA;
    localparam logic [7:0] REG_MAIN = 8'h06;
    localparam logic [7:0] REG_FINE = 8'h07;
    localparam logic [6:0] FINE_MASK = 7'h7F;
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_RANGE = 2'd1;
    localparam logic [1:0] CFG_ADDR = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic scale;
        logic div_step;
        logic check;
        logic second;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic two_frames;
    } t_sts;
endpackage
`default_nettype wire

// ===== hw/rtl/dxpf_req_if.sv =====
// dxpf_req_if: request channel, valid/ready with action and value
// no dependencies
`default_nettype none
interface dxpf_req_if;
    logic valid;
    logic ready;
    logic action;
    logic signed [23:0] value;
    modport source (output valid, action, value, input ready);
    modport sink (input valid, action, value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dxpf_rsp_if.sv =====
// dxpf_rsp_if: result channel, valid/ready with frame and report fields
// no dependencies
`default_nettype none
interface dxpf_rsp_if;
    logic valid;
    logic ready;
    logic status;
    logic frame_valid;
    logic [39:0] frame;
    logic last;
    logic signed [22:0] applied_code;
    logic signed [21:0] applied_ppb;
    logic [31:0] write_count;
    modport source (output valid, status, frame_valid, frame, last, applied_code,
        applied_ppb, write_count, input ready);
    modport sink (input valid, status, frame_valid, frame, last, applied_code,
        applied_ppb, write_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dxpf_ctrl.sv =====
// dxpf_ctrl: sequencing state machine for the pull frame encoder
// depends on dxpf_pkg
`default_nettype none
module dxpf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output dxpf_pkg::t_cmd   o_cmd,
    input  dxpf_pkg::t_sts   i_sts
);
    import dxpf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCALE, S_DIV, S_CHECK, S_OUT1, S_OUT2
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_MUL;
                S_MUL:   r_state <= S_SCALE;
                S_SCALE: r_state <= S_DIV;
                S_DIV:   if (i_sts.div_done) r_state <= S_CHECK;
                S_CHECK: r_state <= S_OUT1;
                S_OUT1: begin
                    if (i_out_ready) r_state <= i_sts.two_frames ? S_OUT2 : S_IDLE;
                end
                S_OUT2:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT1) || (r_state == S_OUT2);

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul = (r_state == S_MUL);
        o_cmd.scale = (r_state == S_SCALE);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.check = (r_state == S_CHECK);
        o_cmd.second = (r_state == S_OUT1) && i_out_ready && i_sts.two_frames;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dxpf_dp.sv =====
// dxpf_dp: config registers, multiplier, serial divider, frame builder, counter
// depends on dxpf_pkg
`default_nettype none
module dxpf_dp (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_idx,
    input  wire  [3:0]         i_cfg_data,
    input  wire                i_action,
    input  wire  signed [23:0] i_value,
    input  dxpf_pkg::t_cmd     i_cmd,
    output dxpf_pkg::t_sts     o_sts,
    output logic               o_status,
    output logic               o_frame_valid,
    output logic [39:0]        o_frame,
    output logic               o_last,
    output logic signed [22:0] o_applied_code,
    output logic signed [21:0] o_applied_ppb,
    output logic [31:0]        o_write_count
);
    import dxpf_pkg::*;

    logic r_mode;
    logic [2:0] r_sel;
    logic [3:0] r_addr;
    logic [31:0] r_wcnt;
    logic r_action, r_neg, r_oor;
    logic [23:0] r_mag;
    logic [45:0] r_prod;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den, r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [22:0] r_code;
    logic [21:0] r_ppb;

    logic [2:0] w_sel;
    logic [21:0] w_mul_k;
    logic [NUM_W-1:0] w_scaled;
    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic w_ge;
    logic [22:0] w_cmag;
    logic w_big;
    logic [22:0] w_code;
    logic [21:0] w_ppb;
    logic [15:0] w_hdr;

    assign w_sel = (r_sel == 3'd7) ? 3'd6 : r_sel;
    assign w_mul_k = r_action ? RANGE_K : (r_mode ? LIMIT_M1 : LIMIT_M0);

    always_comb begin
        if (r_action) begin
            w_scaled = NUM_W'({8'd0, r_prod} << w_sel);
        end else begin
            w_scaled = NUM_W'({8'd0, r_prod} << 7) + NUM_W'({8'd0, r_prod} << 5);
        end
    end

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_diff = w_trial - {1'b0, r_den};
    assign w_ge = (w_trial >= {1'b0, r_den});

    // quotient holds the code magnitude for ppb requests, ppb magnitude for raw codes
    assign w_big = r_action ? (r_mag > {2'd0, (r_mode ? LIMIT_M1 : LIMIT_M0)})
                            : (r_num > NUM_W'(r_mode ? LIMIT_M1 : LIMIT_M0));
    assign w_cmag = r_action ? r_mag[22:0] : r_num[22:0];
    assign w_code = r_neg ? (23'd0 - w_cmag) : w_cmag;
    assign w_ppb = r_action ? (r_neg ? (22'd0 - r_num[21:0]) : r_num[21:0])
                            : (r_neg ? (22'd0 - r_mag[21:0]) : r_mag[21:0]);
    assign w_hdr = {HDR_HI, r_addr, HDR_LO};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_sel <= 3'd0;
            r_addr <= 4'd0;
            r_wcnt <= 32'd0;
            r_cnt <= '0;
            r_oor <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:  r_mode <= i_cfg_data[0];
                    CFG_RANGE: r_sel <= i_cfg_data[2:0];
                    CFG_ADDR:  r_addr <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (i_cmd.scale) r_cnt <= CNT_W'(NUM_W);
            if (i_cmd.div_step) r_cnt <= r_cnt - 1'b1;
            if (i_cmd.check) begin
                r_oor <= w_big;
                if (!w_big) r_wcnt <= r_wcnt + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_neg <= i_value[23];
            r_mag <= i_value[23] ? (24'd0 - i_value) : i_value;
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * w_mul_k;
            r_den <= r_action ? (r_mode ? DEN_M1 : DEN_M0)
                              : DEN_W'({9'd0, RANGE_K} << w_sel);
        end
        if (i_cmd.scale) begin
            r_num <= w_scaled + NUM_W'(r_den >> 1);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
        if (i_cmd.check) begin
            r_code <= w_code;
            r_ppb <= w_ppb;
        end
        if (i_cmd.second) begin
            o_frame <= {w_hdr, REG_MAIN, r_code[22:7]};
            o_last <= 1'b1;
        end else if (i_cmd.check) begin
            o_status <= w_big;
            o_frame_valid <= !w_big;
            o_last <= w_big || !r_mode;
            o_applied_code <= w_big ? 23'd0 : w_code;
            o_applied_ppb <= w_big ? 22'd0 : w_ppb;
            o_write_count <= w_big ? r_wcnt : (r_wcnt + 32'd1);
            if (w_big) o_frame <= 40'd0;
            else if (r_mode) o_frame <= {w_hdr, REG_FINE, 9'd0, w_code[6:0] & FINE_MASK};
            else o_frame <= {w_hdr, REG_MAIN, w_code[15:0]};
        end
    end

    assign o_sts.div_done = (r_cnt == CNT_W'(1));
    assign o_sts.two_frames = r_mode && !r_oor;
endmodule
`default_nettype wire

// ===== hw/rtl/dcxo_pull_frame_encoder.sv =====
// dcxo_pull_frame_encoder: top level of the oscillator pull frame encoder
// depends on dxpf_pkg, dxpf_req_if, dxpf_rsp_if, dxpf_ctrl, dxpf_dp
// flow: multiply, scale, 54-step bit-serial divide and range check, then result words
// throughput: a new request is taken only once the last result word of the
//   previous request has been accepted
// reset: synchronous active low, clears config, write counter and controller
`default_nettype none
module dcxo_pull_frame_encoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [1:0] i_cfg_idx,
    input  wire  [3:0] i_cfg_data,
    dxpf_req_if.sink   i_req,
    dxpf_rsp_if.source o_rsp
);
    import dxpf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    dxpf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    dxpf_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_action(i_req.action), .i_value(i_req.value),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .o_status(o_rsp.status), .o_frame_valid(o_rsp.frame_valid),
        .o_frame(o_rsp.frame), .o_last(o_rsp.last),
        .o_applied_code(o_rsp.applied_code), .o_applied_ppb(o_rsp.applied_ppb),
        .o_write_count(o_rsp.write_count)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/dxpf_checker.sv =====
// dxpf_checker: port-level assertions for dcxo_pull_frame_encoder, with bind
// depends on dcxo_pull_frame_encoder port names
`default_nettype none
module dxpf_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_status,
    input wire i_frame_valid,
    input wire i_last
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("ready while result pending");
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid) else $error("result too early");
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status) |-> (i_last && !i_frame_valid))
        else $error("bad reject word");
    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_status) |-> i_frame_valid) else $error("missing frame");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid) else $error("word dropped");
endmodule

bind dcxo_pull_frame_encoder dxpf_checker u_dxpf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
    .i_status(o_rsp.status), .i_frame_valid(o_rsp.frame_valid), .i_last(o_rsp.last)
);
`default_nettype wire

// ===== verif/dcxo_pull_frame_encoder_tb.sv =====
// dcxo_pull_frame_encoder_tb: self-checking testbench for the pull frame encoder
// drives requests and config writes, predicts result words, checks them in order
// depends on dxpf_pkg, dxpf_req_if, dxpf_rsp_if and dcxo_pull_frame_encoder
`timescale 1ns / 100ps
module dcxo_pull_frame_encoder_tb;
    import dxpf_pkg::*;

    typedef struct {
        bit        status;
        bit        frame_valid;
        bit [39:0] frame;
        bit        last;
        bit [22:0] code;
        bit [21:0] ppb;
        bit [31:0] count;
    } pull_word_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [3:0] i_cfg_data = '0;

    dxpf_req_if req ();
    dxpf_rsp_if rsp ();

    dcxo_pull_frame_encoder DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req(req),
        .o_rsp(rsp)
    );

    always #5 i_clk = ~i_clk;

    pull_word_t pending_words[$];
    int         errors = 0;
    int         hold_cycles = 0;
    bit         m_mode = 1'b0;
    bit [2:0]   m_range_sel = '0;
    bit [3:0]   m_addr = '0;
    bit [31:0]  m_writes = '0;

    initial begin
        req.valid = 1'b0;
        req.action = 1'b0;
        req.value = '0;
        rsp.ready = 1'b0;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic bit [39:0] build_frame(bit [7:0] regno, bit [15:0] data);
        return {8'hFA, m_addr, 4'hA, regno, data};
    endfunction

    task automatic predict_pull(bit act, logic signed [23:0] v);
        longint     val, lim, rng, code, ppb;
        bit [22:0]  c23;
        pull_word_t w;
        val = v;
        rng = 25 << ((m_range_sel > 6) ? 6 : m_range_sel);
        lim = m_mode ? 4194303 : 32767;
        code = act ? val : round_div(val * lim * 160, rng * 160217);
        w.status = 1'b0;
        w.frame_valid = 1'b1;
        if (code > lim || code < -lim) begin
            w = '{1'b1, 1'b0, 40'd0, 1'b1, 23'd0, 22'd0, m_writes};
            pending_words.push_back(w);
            return;
        end
        ppb = act ? round_div(code * rng * 160217, lim * 160) : val;
        m_writes++;
        w.code = code[22:0];
        w.ppb = ppb[21:0];
        w.count = m_writes;
        c23 = code[22:0];
        if (!m_mode) begin
            w.frame = build_frame(REG_MAIN, code[15:0]);
            w.last = 1'b1;
            pending_words.push_back(w);
        end else begin
            w.frame = build_frame(REG_FINE, {9'd0, c23[6:0]});
            w.last = 1'b0;
            pending_words.push_back(w);
            w.frame = build_frame(REG_MAIN, c23[22:7]);
            w.last = 1'b1;
            pending_words.push_back(w);
        end
    endtask

    task automatic send_pull(bit act, logic signed [23:0] v, bit no_gap = 1'b0);
        int  gap;
        bit  acc;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.value <= v;
        forever begin
            @(negedge i_clk);
            acc = req.ready;
            @(posedge i_clk);
            if (acc) break;
        end
        predict_pull(act, v);
    endtask

    task automatic drain_pulls();
        @(posedge i_clk);
        req.valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [3:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:  m_mode = data[0];
            CFG_RANGE: m_range_sel = data[2:0];
            CFG_ADDR:  m_addr = data;
            default: ;
        endcase
    endtask

    task automatic set_cfg(bit md, bit [2:0] sel, bit [3:0] addr);
        write_cfg(CFG_MODE, {3'd0, md});
        write_cfg(CFG_RANGE, {1'b0, sel});
        write_cfg(CFG_ADDR, addr);
    endtask

    // receiver: random stalls per word, plus a long hold-off on request
    initial begin
        int  gap;
        bit  acc;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                rsp.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            forever begin
                @(negedge i_clk);
                acc = rsp.valid;
                @(posedge i_clk);
                if (acc) break;
            end
        end
    end

    always @(negedge i_clk) begin
        pull_word_t e;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, got frame %h", $time, rsp.frame);
                errors++;
            end else begin
                e = pending_words.pop_front();
                if ({rsp.status, rsp.frame_valid, rsp.frame, rsp.last, rsp.applied_code,
                     rsp.applied_ppb, rsp.write_count} !==
                    {e.status, e.frame_valid, e.frame, e.last, e.code, e.ppb, e.count}) begin
                    $display("%0t: mismatch exp st=%b fv=%b fr=%h last=%b code=%h ppb=%h cnt=%0d",
                        $time, e.status, e.frame_valid, e.frame, e.last, e.code, e.ppb,
                        e.count);
                    $display("%0t:          got st=%b fv=%b fr=%h last=%b code=%h ppb=%h cnt=%0d",
                        $time, rsp.status, rsp.frame_valid, rsp.frame, rsp.last,
                        rsp.applied_code, rsp.applied_ppb, rsp.write_count);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        for (int md = 0; md < 2; md++) begin
            set_cfg(md[0], md ? 3'd6 : 3'd0, md ? 4'hF : 4'h0);
            send_pull(1'b0, 24'sd0);
            send_pull(1'b0, 24'sd25000);
            send_pull(1'b0, -24'sd25000);
            send_pull(1'b0, 24'sd8388607);
            send_pull(1'b0, -24'sd8388608);
            send_pull(1'b0, 24'sd1);
            send_pull(1'b0, -24'sd1);
            send_pull(1'b1, md ? 24'sd4194303 : 24'sd32767);
            send_pull(1'b1, md ? -24'sd4194303 : -24'sd32767);
            send_pull(1'b1, md ? 24'sd4194304 : 24'sd32768);
            send_pull(1'b1, md ? -24'sd4194304 : -24'sd32768);
            send_pull(1'b1, 24'sd8388607);
            send_pull(1'b1, -24'sd8388608);
            drain_pulls();
        end
    endtask

    task automatic random_pull(bit no_gap = 1'b0);
        longint lim, span, v;
        int     kind;
        lim = m_mode ? 4194303 : 32767;
        span = (25 << ((m_range_sel > 6) ? 6 : m_range_sel)) * 1000 + 50;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            v = longint'($urandom_range(0, 2 * span)) - span;
            send_pull(1'b0, v[23:0], no_gap);
        end else if (kind < 8) begin
            v = longint'($urandom_range(0, 2 * lim + 4)) - lim - 2;
            send_pull(1'b1, v[23:0], no_gap);
        end else begin
            send_pull(1'($urandom_range(0, 1)), 24'($urandom()), no_gap);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 16; ph++) begin
            set_cfg(ph[0], ph[3:1] % 8, 4'($urandom_range(0, 15)));
            repeat (100) random_pull();
            drain_pulls();
        end
    endtask

    task automatic test_backpressure();
        set_cfg(1'b1, 3'd2, 4'h5);
        hold_cycles = 600;
        repeat (30) random_pull(1'b1);
        drain_pulls();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        if (errors == 0) begin
            $display("dcxo_pull_frame_encoder_tb: done, clean");
        end else begin
            $display("dcxo_pull_frame_encoder_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("dcxo_pull_frame_encoder_tb: done, errors");
        $finish;
    end
endmodule
